FILE: hdl/lusl_pkg.sv
`default_nettype none

package lusl_pkg;

  // Field and table geometry
  localparam int SYM_W    = 8;
  localparam int POS_W    = 16;
  localparam int ALPHABET = 1 << SYM_W;

  // Positions at or past this value are beyond the string range
  localparam logic [POS_W-1:0] POS_LIMIT = {POS_W{1'b1}};

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [POS_W-1:0] pos_t;

  // Write and clear request into the position table
  typedef struct packed {
    logic en;
    logic clear;
    sym_t addr;
    pos_t data;
  } tbl_wr_t;

  // Lookup result for the byte in the compute stage
  typedef struct packed {
    logic seen;
    pos_t pos;
  } tbl_rd_t;

endpackage

`default_nettype wire

FILE: hdl/lusl_if.sv
`default_nettype none

// Input channel: one string byte per beat
interface lusl_in_if;
  logic               valid;
  logic               ready;
  lusl_pkg::sym_t     char_byte;
  logic               end_of_string;

  modport source (output valid, output char_byte, output end_of_string, input ready);
  modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

// Result channel: one result per input beat
interface lusl_out_if;
  logic               valid;
  logic               ready;
  lusl_pkg::pos_t     longest_so_far;
  logic               string_done;
  logic               length_overflow;

  modport source (output valid, output longest_so_far, output string_done,
                  output length_overflow, input ready);
  modport sink   (input valid, input longest_so_far, input string_done,
                  input length_overflow, output ready);
endinterface

`default_nettype wire

FILE: hdl/lusl_table.sv
`default_nettype none

module lusl_table (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     rd_en,
  input  wire lusl_pkg::sym_t     rd_addr,
  input  wire lusl_pkg::sym_t     look_addr,
  input  wire lusl_pkg::tbl_wr_t  wr,
  output lusl_pkg::tbl_rd_t       look
);

  // Last position of each byte value, read data registered
  lusl_pkg::pos_t mem [lusl_pkg::ALPHABET];
  lusl_pkg::pos_t rd_data_r;

  // Seen bits, cleared all at once at end of string
  logic [lusl_pkg::ALPHABET-1:0] seen_r;
  logic [lusl_pkg::ALPHABET-1:0] seen_nxt;

  // Write landing on the same edge as the read: bypass the stale read data
  logic           fwd_valid_r;
  lusl_pkg::sym_t fwd_addr_r;
  lusl_pkg::pos_t fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    if (wr.en) begin
      seen_nxt[wr.addr] = 1'b1;
    end
    if (wr.clear) begin
      seen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      if (rd_en) begin
        fwd_valid_r <= wr.en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_addr_r <= wr.addr;
      fwd_data_r <= wr.data;
    end
  end

  // Lookup for the byte now in the compute stage
  always_comb begin
    look.seen = seen_r[look_addr];
    look.pos  = (fwd_valid_r && (fwd_addr_r == look_addr)) ? fwd_data_r : rd_data_r;
  end

endmodule

`default_nettype wire

FILE: hdl/longest_unique_substring_length_top.sv
// Longest repeat-free substring length over a byte stream.
//
// in_ch carries one string byte per beat with end_of_string on the last
// byte; out_ch returns exactly one result beat per input beat, in order:
// the best repeat-free length so far, string_done (echo of end_of_string)
// and length_overflow (string ran past 65535 bytes; length held).
// Both channels use valid/ready; a beat moves when both are high.
//
// The position memory is read on the edge that takes a byte into the
// compute stage; the window update then loads the output register.
// Throughput is one byte per cycle while out_ch does not stall; a write
// landing on the cycle of the next read is forwarded to the lookup.
// After the last byte of a string the seen bits clear in that same cycle,
// so the next string may follow immediately.
// Reset clears the pipeline, the seen bits and the window state; the
// position memory itself is not cleared. When out_ch stalls, the output
// register holds its beat, one more byte waits in the compute stage, and
// in_ch.ready drops until the output beat is taken.
`default_nettype none

module longest_unique_substring_length_top (
  input  wire          clk,
  input  wire          rst_n,
  lusl_in_if.sink      in_ch,
  lusl_out_if.source   out_ch
);

  // Compute stage holding register
  logic           s1_valid_r;
  lusl_pkg::sym_t s1_sym_r;
  logic           s1_last_r;

  // Per-string state
  lusl_pkg::pos_t byte_pos_r,  byte_pos_nxt;
  lusl_pkg::pos_t win_start_r, win_start_nxt;
  lusl_pkg::pos_t best_r,      best_nxt;
  logic           ovf_r,       ovf_nxt;

  // Output register
  logic           out_valid_r;
  lusl_pkg::pos_t out_len_r;
  logic           out_done_r;
  logic           out_ovf_r;

  logic              accept;
  logic              advance;
  logic              at_limit;
  lusl_pkg::pos_t    start_cur;
  lusl_pkg::pos_t    len_cur;
  logic              new_best;
  lusl_pkg::tbl_wr_t wr;
  lusl_pkg::tbl_rd_t look;

  // Handshake
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  lusl_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr   (in_ch.char_byte),
    .look_addr (s1_sym_r),
    .wr        (wr),
    .look      (look)
  );

  // Window update for the byte in the compute stage
  always_comb begin
    at_limit  = (byte_pos_r == lusl_pkg::POS_LIMIT);
    start_cur = win_start_r;
    if (look.seen && (look.pos >= win_start_r)) begin
      start_cur = look.pos + lusl_pkg::pos_t'(1);
    end
    len_cur  = byte_pos_r - start_cur + lusl_pkg::pos_t'(1);
    new_best = (len_cur > best_r);

    byte_pos_nxt  = byte_pos_r;
    win_start_nxt = win_start_r;
    best_nxt      = best_r;
    ovf_nxt       = ovf_r;
    if (at_limit) begin
      ovf_nxt = 1'b1;
    end else begin
      byte_pos_nxt  = byte_pos_r + lusl_pkg::pos_t'(1);
      win_start_nxt = start_cur;
      if (new_best) begin
        best_nxt = len_cur;
      end
    end

    wr.en    = advance && !at_limit;
    wr.clear = advance && s1_last_r;
    wr.addr  = s1_sym_r;
    wr.data  = byte_pos_r;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byte_pos_r  <= '0;
      win_start_r <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (advance) begin
        if (s1_last_r) begin
          byte_pos_r  <= '0;
          win_start_r <= '0;
          best_r      <= '0;
          ovf_r       <= 1'b0;
        end else begin
          byte_pos_r  <= byte_pos_nxt;
          win_start_r <= win_start_nxt;
          best_r      <= best_nxt;
          ovf_r       <= ovf_nxt;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sym_r  <= in_ch.char_byte;
      s1_last_r <= in_ch.end_of_string;
    end
    if (advance) begin
      out_len_r  <= best_nxt;
      out_done_r <= s1_last_r;
      out_ovf_r  <= ovf_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.longest_so_far  = out_len_r;
  assign out_ch.string_done     = out_done_r;
  assign out_ch.length_overflow = out_ovf_r;

endmodule

`default_nettype wire

FILE: hdl/lusl_checker.sv
`default_nettype none

module lusl_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire [15:0]          out_len,
  input wire                 out_done,
  input wire                 out_ovf
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // Stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_len) && $stable(out_done) && $stable(out_ovf))
    else $error("result payload changed while stalled");

  // Byte taken and receiver ready next cycle: its result is presented
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat ##1 out_ready |=> out_valid)
    else $error("result missing two cycles after byte");

  // Every string has at least one byte, so a result length is never zero
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_len != 16'd0)
    else $error("zero length result");

  // Nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind longest_unique_substring_length_top lusl_checker u_lusl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_len   (out_ch.longest_so_far),
  .out_done  (out_ch.string_done),
  .out_ovf   (out_ch.length_overflow)
);

`default_nettype wire
